>>> hw/rtl/isingm_pkg.sv
// Shared types and constants for the Ising Metropolis spin update block.
// No dependencies; the RTL refers to this package by scoped names, the bench imports it.
`default_nettype none

package isingm_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_THRESH_FOUR  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESH_EIGHT = 2'd1;

    // stream words
    localparam int SITE_FIELD_W = 5;
    localparam int DRAW_W       = 32;
    localparam int IN_DATA_W    = 48;
    localparam int OUT_DATA_W   = 288;

    localparam int ENERGY_NOW_W = 13;
    localparam int MAGNET_NOW_W = 12;
    localparam int ACC_W        = 64;

    // depth of the result queue; the back end reserves a slot per started item
    localparam int OUT_DEPTH = 4;

    // first member lands in the highest bits, so flip_accepted sits at bit 0
    typedef struct packed {
        logic [ACC_W-1:0]        magnet_sq_sum;
        logic [ACC_W-1:0]        abs_magnet_sum;
        logic [ACC_W-1:0]        energy_sq_sum;
        logic [ACC_W-1:0]        energy_sum;
        logic [MAGNET_NOW_W-1:0] magnet_now;
        logic [ENERGY_NOW_W-1:0] energy_now;
        logic                    flip_accepted;
    } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/isingm_fifo.sv
// Small register queue with a valid/ready style head.
// Standalone; used by the front end and the top level.
`default_nettype none

module isingm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output logic [WIDTH-1:0]      head_data
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   entries [0:DEPTH-1];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    assign full       = (count_reg == COUNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + COUNT_W'(push) - COUNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/isingm_front.sv
// Front end: takes input words, wraps the site into the lattice, works out the
// four neighbor indices and queues the decoded item. Uses isingm_pkg, isingm_fifo.
`default_nettype none

module isingm_front #(
    parameter int LATTICE_SIDE = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [isingm_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic                              clearing,
    output logic                                   q_valid,
    output logic [6*$clog2(LATTICE_SIDE)+isingm_pkg::DRAW_W-1:0] q_data,
    input  wire logic                              q_pop
);

    localparam int IDX_W    = $clog2(LATTICE_SIDE);
    localparam int ITEM_W   = 6 * IDX_W + isingm_pkg::DRAW_W;
    localparam int FIELD_W  = isingm_pkg::SITE_FIELD_W;
    localparam int LUT_SIZE = 2 ** FIELD_W;
    localparam int Q_DEPTH  = 2;

    logic [IDX_W-1:0]              wrap_lut [0:LUT_SIZE-1];
    logic [FIELD_W-1:0]            site_row;
    logic [FIELD_W-1:0]            site_col;
    logic [isingm_pkg::DRAW_W-1:0] uniform_draw;
    logic [IDX_W-1:0]              row;
    logic [IDX_W-1:0]              col;
    logic [IDX_W-1:0]              row_plus;
    logic [IDX_W-1:0]              row_minus;
    logic [IDX_W-1:0]              col_plus;
    logic [IDX_W-1:0]              col_minus;
    logic                          q_full;
    logic                          accept;
    logic [ITEM_W-1:0]             item;

    // site field reduced modulo the lattice side, folded at elaboration
    for (genvar i = 0; i < LUT_SIZE; i++)
    begin : g_wrap
        assign wrap_lut[i] = IDX_W'(i % LATTICE_SIDE);
    end

    assign site_row     = s_tdata[FIELD_W-1:0];
    assign site_col     = s_tdata[2*FIELD_W-1:FIELD_W];
    assign uniform_draw = s_tdata[2*FIELD_W+isingm_pkg::DRAW_W-1:2*FIELD_W];

    assign row = wrap_lut[site_row];
    assign col = wrap_lut[site_col];

    always_comb
    begin
        row_plus  = (row == IDX_W'(LATTICE_SIDE - 1)) ? '0 : row + IDX_W'(1);
        row_minus = (row == '0) ? IDX_W'(LATTICE_SIDE - 1) : row - IDX_W'(1);
        col_plus  = (col == IDX_W'(LATTICE_SIDE - 1)) ? '0 : col + IDX_W'(1);
        col_minus = (col == '0) ? IDX_W'(LATTICE_SIDE - 1) : col - IDX_W'(1);
    end

    // hold off input while the queue is full or until the lattice is swept to all spins up
    assign s_tready = !q_full && !clearing;
    assign accept   = s_tvalid && s_tready;
    assign item     = {uniform_draw, col_minus, col_plus, col, row_minus, row_plus, row};

    isingm_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_data)
    );

endmodule

`default_nettype wire

>>> hw/rtl/isingm_lattice.sv
// Spin lattice memory: one row of spins per word, two read ports with registered,
// write-first data, one write port, and a sweep that sets every spin up after reset.
`default_nettype none

module isingm_lattice #(
    parameter int LATTICE_SIDE = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [$clog2(LATTICE_SIDE)-1:0]  rd0_addr,
    input  wire logic [$clog2(LATTICE_SIDE)-1:0]  rd1_addr,
    output logic [LATTICE_SIDE-1:0]               rd0_data,
    output logic [LATTICE_SIDE-1:0]               rd1_data,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(LATTICE_SIDE)-1:0]  wr_addr,
    input  wire logic [LATTICE_SIDE-1:0]          wr_data,
    output logic                                  clearing
);

    localparam int IDX_W = $clog2(LATTICE_SIDE);

    logic [LATTICE_SIDE-1:0] rows_mem [0:LATTICE_SIDE-1];
    logic [LATTICE_SIDE-1:0] rd0_data_reg;
    logic [LATTICE_SIDE-1:0] rd1_data_reg;
    logic                    clearing_reg;
    logic [IDX_W-1:0]        clear_idx_reg;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [LATTICE_SIDE-1:0] mem_wdata;

    assign clearing = clearing_reg;
    assign rd0_data = rd0_data_reg;
    assign rd1_data = rd1_data_reg;

    always_comb
    begin
        mem_we    = clearing_reg || wr_en;
        mem_waddr = clearing_reg ? clear_idx_reg : wr_addr;
        mem_wdata = clearing_reg ? '1 : wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clear_idx_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clear_idx_reg == IDX_W'(LATTICE_SIDE - 1))
            begin
                clearing_reg <= 1'b0;
            end
            else
            begin
                clear_idx_reg <= clear_idx_reg + IDX_W'(1);
            end
        end
    end

    // a read of the row being written returns the new row
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rows_mem[mem_waddr] <= mem_wdata;
        end
        rd0_data_reg <= (mem_we && (mem_waddr == rd0_addr)) ? mem_wdata : rows_mem[rd0_addr];
        rd1_data_reg <= (mem_we && (mem_waddr == rd1_addr)) ? mem_wdata : rows_mem[rd1_addr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/isingm_back.sv
// Back end: reads three lattice rows per item, makes the Metropolis decision,
// updates energy and magnetization and the saturating sums.
// Uses isingm_pkg and isingm_lattice.
`default_nettype none

module isingm_back #(
    parameter int LATTICE_SIDE = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 q_valid,
    input  wire logic [6*$clog2(LATTICE_SIDE)+isingm_pkg::DRAW_W-1:0] q_data,
    output logic                                      q_pop,
    input  wire logic [isingm_pkg::CFG_DATA_W-1:0]    thresh_four,
    input  wire logic [isingm_pkg::CFG_DATA_W-1:0]    thresh_eight,
    output logic                                      clearing,
    output logic                                      res_push,
    output isingm_pkg::result_t                       res_data,
    input  wire logic                                 res_pop
);

    localparam int IDX_W    = $clog2(LATTICE_SIDE);
    localparam int DRAW_W   = isingm_pkg::DRAW_W;
    localparam int ACC_W    = isingm_pkg::ACC_W;
    localparam int E_RAW_W  = $clog2(2 * LATTICE_SIDE * LATTICE_SIDE) + 2;
    localparam int DE_W     = 6;
    localparam int E_W      = (E_RAW_W > DE_W) ? E_RAW_W : DE_W;
    localparam int M_W      = $clog2(LATTICE_SIDE * LATTICE_SIDE) + 2;
    localparam int EA_W     = E_W - 1;
    localparam int MA_W     = M_W - 1;
    localparam int CREDIT_W = $clog2(isingm_pkg::OUT_DEPTH + 1);

    localparam logic [E_W-1:0]   ENERGY_RESET = E_W'(-2 * LATTICE_SIDE * LATTICE_SIDE);
    localparam logic [M_W-1:0]   MAGNET_RESET = M_W'(LATTICE_SIDE * LATTICE_SIDE);
    localparam logic [ACC_W-1:0] S_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
    localparam logic [ACC_W-1:0] S_MIN = {1'b1, {(ACC_W - 1){1'b0}}};

    // queue head
    logic [IDX_W-1:0]        q_row;
    logic [IDX_W-1:0]        q_row_plus;
    logic [IDX_W-1:0]        q_row_minus;
    logic [IDX_W-1:0]        q_col;
    logic [IDX_W-1:0]        q_col_plus;
    logic [IDX_W-1:0]        q_col_minus;
    logic [DRAW_W-1:0]       q_draw;
    logic                    start_item;

    // lattice port wiring
    logic [IDX_W-1:0]        rd0_addr;
    logic [LATTICE_SIDE-1:0] rd0_data;
    logic [LATTICE_SIDE-1:0] rd1_data;
    logic                    wr_en;
    logic [LATTICE_SIDE-1:0] wr_data;

    // second read cycle
    logic                    b_valid_reg;
    logic [IDX_W-1:0]        b_row_reg;
    logic [IDX_W-1:0]        b_row_minus_reg;
    logic [IDX_W-1:0]        b_col_reg;
    logic [IDX_W-1:0]        b_col_plus_reg;
    logic [IDX_W-1:0]        b_col_minus_reg;
    logic [DRAW_W-1:0]       b_draw_reg;

    // decision cycle
    logic                    c_valid_reg;
    logic [IDX_W-1:0]        c_row_reg;
    logic [IDX_W-1:0]        c_col_reg;
    logic [IDX_W-1:0]        c_col_plus_reg;
    logic [IDX_W-1:0]        c_col_minus_reg;
    logic [DRAW_W-1:0]       c_draw_reg;
    logic [LATTICE_SIDE-1:0] c_row_data_reg;
    logic                    c_spin_below_reg;
    logic                    spin;
    logic [3:0]              nbr;
    logic [2:0]              aligned;
    logic                    accept;
    logic signed [DE_W-1:0]  delta_e;
    logic [LATTICE_SIDE-1:0] flip_mask;

    logic [E_W-1:0]          energy_reg;
    logic [E_W-1:0]          energy_next;
    logic [M_W-1:0]          magnet_reg;
    logic [M_W-1:0]          magnet_next;

    // squaring cycle
    logic                    d_valid_reg;
    logic                    d_accept_reg;
    logic [E_W-1:0]          d_energy_reg;
    logic [M_W-1:0]          d_magnet_reg;
    logic [E_W-1:0]          e_neg;
    logic [M_W-1:0]          m_neg;
    logic [EA_W-1:0]         e_abs;
    logic [MA_W-1:0]         m_abs;

    // accumulate cycle
    logic                    s_valid_reg;
    logic                    s_accept_reg;
    logic [E_W-1:0]          s_energy_reg;
    logic [M_W-1:0]          s_magnet_reg;
    logic [2*EA_W-1:0]       s_esq_reg;
    logic [MA_W-1:0]         s_mabs_reg;
    logic [2*MA_W-1:0]       s_msq_reg;
    logic [ACC_W-1:0]        energy_ext;
    logic [ACC_W-1:0]        magnet_ext;
    logic [ACC_W-1:0]        e_sum_raw;
    logic [ACC_W:0]          esq_sum_raw;
    logic [ACC_W:0]          mabs_sum_raw;
    logic [ACC_W:0]          msq_sum_raw;

    logic [ACC_W-1:0]        energy_acc_reg;
    logic [ACC_W-1:0]        energy_acc_next;
    logic [ACC_W-1:0]        energy_sq_acc_reg;
    logic [ACC_W-1:0]        energy_sq_acc_next;
    logic [ACC_W-1:0]        abs_magnet_acc_reg;
    logic [ACC_W-1:0]        abs_magnet_acc_next;
    logic [ACC_W-1:0]        magnet_sq_acc_reg;
    logic [ACC_W-1:0]        magnet_sq_acc_next;

    logic [CREDIT_W-1:0]     credit_reg;
    logic [CREDIT_W-1:0]     credit_next;

    assign q_row       = q_data[IDX_W-1:0];
    assign q_row_plus  = q_data[2*IDX_W-1:IDX_W];
    assign q_row_minus = q_data[3*IDX_W-1:2*IDX_W];
    assign q_col       = q_data[4*IDX_W-1:3*IDX_W];
    assign q_col_plus  = q_data[5*IDX_W-1:4*IDX_W];
    assign q_col_minus = q_data[6*IDX_W-1:5*IDX_W];
    assign q_draw      = q_data[6*IDX_W+DRAW_W-1:6*IDX_W];

    // Port 0 is busy with the row above during the second read cycle, so no new
    // item starts while one is in that cycle. Reserve a result slot up front.
    assign start_item = q_valid && !b_valid_reg && !clearing
                        && (credit_reg < CREDIT_W'(isingm_pkg::OUT_DEPTH));
    assign q_pop      = start_item;
    assign rd0_addr   = b_valid_reg ? b_row_minus_reg : q_row;

    isingm_lattice #(
        .LATTICE_SIDE (LATTICE_SIDE)
    ) u_lattice (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd0_addr (rd0_addr),
        .rd1_addr (q_row_plus),
        .rd0_data (rd0_data),
        .rd1_data (rd1_data),
        .wr_en    (wr_en),
        .wr_addr  (c_row_reg),
        .wr_data  (wr_data),
        .clearing (clearing)
    );

    // decision: count neighbors aligned with the site, dE = 4 * aligned - 8
    always_comb
    begin
        spin   = c_row_data_reg[c_col_reg];
        nbr[0] = rd0_data[c_col_reg];
        nbr[1] = c_spin_below_reg;
        nbr[2] = c_row_data_reg[c_col_plus_reg];
        nbr[3] = c_row_data_reg[c_col_minus_reg];
        aligned = 3'(nbr[0] == spin) + 3'(nbr[1] == spin)
                + 3'(nbr[2] == spin) + 3'(nbr[3] == spin);
        case (aligned)
            3'd3:    accept = (c_draw_reg < thresh_four);
            3'd4:    accept = (c_draw_reg < thresh_eight);
            default: accept = 1'b1;
        endcase
        delta_e   = $signed({1'b0, aligned, 2'b00}) - DE_W'(8);
        flip_mask = LATTICE_SIDE'(1) << c_col_reg;
        wr_en     = c_valid_reg && accept;
        wr_data   = c_row_data_reg ^ flip_mask;

        energy_next = energy_reg;
        magnet_next = magnet_reg;
        if (wr_en)
        begin
            energy_next = energy_reg + {{(E_W - DE_W){delta_e[DE_W-1]}}, delta_e};
            magnet_next = spin ? magnet_reg - M_W'(2) : magnet_reg + M_W'(2);
        end
    end

    always_comb
    begin
        e_neg = '0 - d_energy_reg;
        m_neg = '0 - d_magnet_reg;
        e_abs = d_energy_reg[E_W-1] ? e_neg[EA_W-1:0] : d_energy_reg[EA_W-1:0];
        m_abs = d_magnet_reg[M_W-1] ? m_neg[MA_W-1:0] : d_magnet_reg[MA_W-1:0];
    end

    // saturating sums
    always_comb
    begin
        energy_ext   = {{(ACC_W - E_W){s_energy_reg[E_W-1]}}, s_energy_reg};
        magnet_ext   = {{(ACC_W - M_W){s_magnet_reg[M_W-1]}}, s_magnet_reg};
        e_sum_raw    = energy_acc_reg + energy_ext;
        esq_sum_raw  = {1'b0, energy_sq_acc_reg} + (ACC_W + 1)'(s_esq_reg);
        mabs_sum_raw = {1'b0, abs_magnet_acc_reg} + (ACC_W + 1)'(s_mabs_reg);
        msq_sum_raw  = {1'b0, magnet_sq_acc_reg} + (ACC_W + 1)'(s_msq_reg);

        if ((energy_acc_reg[ACC_W-1] == energy_ext[ACC_W-1])
            && (e_sum_raw[ACC_W-1] != energy_acc_reg[ACC_W-1]))
        begin
            energy_acc_next = energy_ext[ACC_W-1] ? S_MIN : S_MAX;
        end
        else
        begin
            energy_acc_next = e_sum_raw;
        end
        energy_sq_acc_next  = esq_sum_raw[ACC_W] ? '1 : esq_sum_raw[ACC_W-1:0];
        abs_magnet_acc_next = mabs_sum_raw[ACC_W] ? '1 : mabs_sum_raw[ACC_W-1:0];
        magnet_sq_acc_next  = msq_sum_raw[ACC_W] ? '1 : msq_sum_raw[ACC_W-1:0];
    end

    always_comb
    begin
        res_push                = s_valid_reg;
        res_data.flip_accepted  = s_accept_reg;
        res_data.energy_now     = energy_ext[isingm_pkg::ENERGY_NOW_W-1:0];
        res_data.magnet_now     = magnet_ext[isingm_pkg::MAGNET_NOW_W-1:0];
        res_data.energy_sum     = energy_acc_next;
        res_data.energy_sq_sum  = energy_sq_acc_next;
        res_data.abs_magnet_sum = abs_magnet_acc_next;
        res_data.magnet_sq_sum  = magnet_sq_acc_next;
        credit_next = credit_reg + CREDIT_W'(start_item) - CREDIT_W'(res_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg        <= 1'b0;
            c_valid_reg        <= 1'b0;
            d_valid_reg        <= 1'b0;
            s_valid_reg        <= 1'b0;
            energy_reg         <= ENERGY_RESET;
            magnet_reg         <= MAGNET_RESET;
            energy_acc_reg     <= '0;
            energy_sq_acc_reg  <= '0;
            abs_magnet_acc_reg <= '0;
            magnet_sq_acc_reg  <= '0;
            credit_reg         <= '0;
        end
        else
        begin
            b_valid_reg <= start_item;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            s_valid_reg <= d_valid_reg;
            energy_reg  <= energy_next;
            magnet_reg  <= magnet_next;
            credit_reg  <= credit_next;
            if (s_valid_reg)
            begin
                energy_acc_reg     <= energy_acc_next;
                energy_sq_acc_reg  <= energy_sq_acc_next;
                abs_magnet_acc_reg <= abs_magnet_acc_next;
                magnet_sq_acc_reg  <= magnet_sq_acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_item)
        begin
            b_row_reg       <= q_row;
            b_row_minus_reg <= q_row_minus;
            b_col_reg       <= q_col;
            b_col_plus_reg  <= q_col_plus;
            b_col_minus_reg <= q_col_minus;
            b_draw_reg      <= q_draw;
        end
        // hold the site row and the spin below while port 0 fetches the row above
        c_row_reg        <= b_row_reg;
        c_col_reg        <= b_col_reg;
        c_col_plus_reg   <= b_col_plus_reg;
        c_col_minus_reg  <= b_col_minus_reg;
        c_draw_reg       <= b_draw_reg;
        c_row_data_reg   <= rd0_data;
        c_spin_below_reg <= rd1_data[b_col_reg];

        d_accept_reg <= accept;
        d_energy_reg <= energy_next;
        d_magnet_reg <= magnet_next;

        s_accept_reg <= d_accept_reg;
        s_energy_reg <= d_energy_reg;
        s_magnet_reg <= d_magnet_reg;
        s_esq_reg    <= e_abs * e_abs;
        s_mabs_reg   <= m_abs;
        s_msq_reg    <= m_abs * m_abs;
    end

endmodule

`default_nettype wire

>>> hw/rtl/ising_metropolis_spin_update.sv
// Ising Metropolis spin update, top level: config registers, front end, back end, result queue.
// Updates are pipelined, but one cannot start while the previous one is still reading: the two
// read ports of the row-wide lattice memory serve rows r, r+1, r-1 per update. An update
// also waits for a free slot in the result queue, so a stalled output holds the input.
// Reset: both thresholds clear to zero; the lattice is then swept to all spins up, one row
// per cycle, with s_tready low. Depends on isingm_pkg, front, back, fifo.
`default_nettype none

module ising_metropolis_spin_update #(
    parameter int LATTICE_SIDE = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // s_tdata: site_row[4:0], site_col[9:5], uniform_draw[41:10], zero fill
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [isingm_pkg::IN_DATA_W-1:0]     s_tdata,
    // m_tdata: flip_accepted[0], energy_now[13:1], magnet_now[25:14], energy_sum[89:26],
    // energy_sq_sum[153:90], abs_magnet_sum[217:154], magnet_sq_sum[281:218], zero fill
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [isingm_pkg::OUT_DATA_W-1:0]         m_tdata,
    input  wire logic                                 cfg_write,
    input  wire logic [isingm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [isingm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int IDX_W    = $clog2(LATTICE_SIDE);
    localparam int ITEM_W   = 6 * IDX_W + isingm_pkg::DRAW_W;
    localparam int RESULT_W = $bits(isingm_pkg::result_t);

    logic [isingm_pkg::CFG_DATA_W-1:0] thresh_four_reg;
    logic [isingm_pkg::CFG_DATA_W-1:0] thresh_eight_reg;

    logic                  clearing;
    logic                  q_valid;
    logic [ITEM_W-1:0]     q_data;
    logic                  q_pop;
    logic                  res_push;
    isingm_pkg::result_t   res_data;
    logic                  res_pop;
    logic                  res_full;
    logic [RESULT_W-1:0]   res_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_four_reg  <= '0;
            thresh_eight_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                isingm_pkg::CFG_THRESH_FOUR:  thresh_four_reg  <= cfg_data;
                isingm_pkg::CFG_THRESH_EIGHT: thresh_eight_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    isingm_front #(
        .LATTICE_SIDE (LATTICE_SIDE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .clearing (clearing),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    isingm_back #(
        .LATTICE_SIDE (LATTICE_SIDE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .thresh_four  (thresh_four_reg),
        .thresh_eight (thresh_eight_reg),
        .clearing     (clearing),
        .res_push     (res_push),
        .res_data     (res_data),
        .res_pop      (res_pop)
    );

    // the back end never pushes without a reserved slot, so full is not needed here
    isingm_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (isingm_pkg::OUT_DEPTH)
    ) u_result_q (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_push),
        .push_data  (res_data),
        .full       (res_full),
        .pop        (res_pop),
        .head_valid (m_tvalid),
        .head_data  (res_head)
    );

    assign res_pop = m_tvalid && m_tready && !(res_full && 1'b0);
    assign m_tdata = {{(isingm_pkg::OUT_DATA_W - RESULT_W){1'b0}}, res_head};

endmodule

`default_nettype wire

>>> bench/lattice_tracker_pkg.sv
// Lattice tracker for the spin update bench: a copy of the spin lattice, running totals
// and thresholds that predicts each report word and checks the words the block returns.
// Depends on isingm_pkg for the report layout, field widths and register indexes.
package lattice_tracker_pkg;

    import isingm_pkg::*;

    localparam int SIDE       = 32;
    localparam int SITE_TOTAL = SIDE * SIDE;

    class lattice_tracker;
        bit [SITE_TOTAL-1:0]     spin_up;
        int                      energy;
        int                      magnet;
        logic signed [ACC_W-1:0] energy_acc;
        logic [ACC_W-1:0]        energy_sq_acc;
        logic [ACC_W-1:0]        abs_magnet_acc;
        logic [ACC_W-1:0]        magnet_sq_acc;
        logic [DRAW_W-1:0]       thresh_four;
        logic [DRAW_W-1:0]       thresh_eight;
        result_t                 predicted_reports[$];
        int                      fail_count;

        function new();
            spin_up        = '1;
            energy         = -2 * SITE_TOTAL;
            magnet         = SITE_TOTAL;
            energy_acc     = '0;
            energy_sq_acc  = '0;
            abs_magnet_acc = '0;
            magnet_sq_acc  = '0;
            thresh_four    = '0;
            thresh_eight   = '0;
            fail_count     = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            if (index == CFG_THRESH_FOUR)
                thresh_four = value;
            else if (index == CFG_THRESH_EIGHT)
                thresh_eight = value;
        endfunction

        function int spin_of(int row, int col);
            return spin_up[(row % SIDE) * SIDE + (col % SIDE)] ? 1 : -1;
        endfunction

        function logic signed [ACC_W-1:0] clamp_add_signed(logic signed [ACC_W-1:0] acc,
                                                           int step);
            logic signed [ACC_W:0] wide;
            wide = acc + step;
            // top two bits disagree: clamp toward the sign of the true sum
            if (wide[ACC_W] != wide[ACC_W-1])
                return wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
            return wide[ACC_W-1:0];
        endfunction

        function logic [ACC_W-1:0] clamp_add(logic [ACC_W-1:0] acc, logic [ACC_W-1:0] step);
            logic [ACC_W:0] wide;
            wide = {1'b0, acc} + {1'b0, step};
            return wide[ACC_W] ? {ACC_W{1'b1}} : wide[ACC_W-1:0];
        endfunction

        // Apply one Metropolis step and queue the report word it should produce.
        function void take_site(logic [SITE_FIELD_W-1:0] row_in,
                                logic [SITE_FIELD_W-1:0] col_in,
                                logic [DRAW_W-1:0] draw);
            int              row;
            int              col;
            int              own;
            int              near_sum;
            int              delta_e;
            bit              flip;
            longint unsigned e_mag;
            longint unsigned m_mag;
            result_t         rpt;
            row      = int'(row_in) % SIDE;
            col      = int'(col_in) % SIDE;
            own      = spin_of(row, col);
            near_sum = spin_of(row + 1, col) + spin_of(row + SIDE - 1, col)
                     + spin_of(row, col + 1) + spin_of(row, col + SIDE - 1);
            delta_e  = 2 * own * near_sum;
            if (delta_e <= 0)
                flip = 1'b1;
            else if (delta_e == 4)
                flip = draw < thresh_four;
            else
                flip = draw < thresh_eight;
            if (flip)
            begin
                spin_up[row * SIDE + col] = ~spin_up[row * SIDE + col];
                energy = energy + delta_e;
                magnet = magnet - 2 * own;
            end
            e_mag = (energy < 0) ? -energy : energy;
            m_mag = (magnet < 0) ? -magnet : magnet;
            energy_acc     = clamp_add_signed(energy_acc, energy);
            energy_sq_acc  = clamp_add(energy_sq_acc, e_mag * e_mag);
            abs_magnet_acc = clamp_add(abs_magnet_acc, m_mag);
            magnet_sq_acc  = clamp_add(magnet_sq_acc, m_mag * m_mag);
            rpt.flip_accepted  = flip;
            rpt.energy_now     = energy[ENERGY_NOW_W-1:0];
            rpt.magnet_now     = magnet[MAGNET_NOW_W-1:0];
            rpt.energy_sum     = energy_acc;
            rpt.energy_sq_sum  = energy_sq_acc;
            rpt.abs_magnet_sum = abs_magnet_acc;
            rpt.magnet_sq_sum  = magnet_sq_acc;
            predicted_reports.push_back(rpt);
        endfunction

        function void match_report(logic [OUT_DATA_W-1:0] word);
            result_t got;
            result_t want;
            got = word[$bits(result_t)-1:0];
            if (predicted_reports.size() == 0)
            begin
                $error("report word arrived with no site update pending");
                fail_count++;
                return;
            end
            want = predicted_reports.pop_front();
            if (got.flip_accepted !== want.flip_accepted)
            begin
                $error("flip_accepted: expected %0d, got %0d",
                       want.flip_accepted, got.flip_accepted);
                fail_count++;
            end
            if (got.energy_now !== want.energy_now)
            begin
                $error("energy_now: expected %0d, got %0d",
                       $signed(want.energy_now), $signed(got.energy_now));
                fail_count++;
            end
            if (got.magnet_now !== want.magnet_now)
            begin
                $error("magnet_now: expected %0d, got %0d",
                       $signed(want.magnet_now), $signed(got.magnet_now));
                fail_count++;
            end
            if (got.energy_sum !== want.energy_sum)
            begin
                $error("energy_sum: expected %0d, got %0d",
                       $signed(want.energy_sum), $signed(got.energy_sum));
                fail_count++;
            end
            if (got.energy_sq_sum !== want.energy_sq_sum)
            begin
                $error("energy_sq_sum: expected %0d, got %0d",
                       want.energy_sq_sum, got.energy_sq_sum);
                fail_count++;
            end
            if (got.abs_magnet_sum !== want.abs_magnet_sum)
            begin
                $error("abs_magnet_sum: expected %0d, got %0d",
                       want.abs_magnet_sum, got.abs_magnet_sum);
                fail_count++;
            end
            if (got.magnet_sq_sum !== want.magnet_sq_sum)
            begin
                $error("magnet_sq_sum: expected %0d, got %0d",
                       want.magnet_sq_sum, got.magnet_sq_sum);
                fail_count++;
            end
        endfunction

        function int pending();
            return predicted_reports.size();
        endfunction
    endclass

endpackage

>>> bench/tb_top.sv
// Top of the spin update bench: clock, reset, stream and register drivers, report monitor
// and stall watchdog. Depends on isingm_pkg, lattice_tracker_pkg and the block's RTL.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import isingm_pkg::*;
    import lattice_tracker_pkg::*;

    // indexes the block does not decode; writes there must change nothing
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam int PHASE_ITEMS   = 220;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 3000;

    // exp(-4/T) and exp(-8/T) scaled by 2^32 near the critical temperature
    localparam logic [DRAW_W-1:0] CRIT_FOUR  = 32'd736_878_000;
    localparam logic [DRAW_W-1:0] CRIT_EIGHT = 32'd126_427_000;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int                      send_idle_pct  = 0;
    int                      recv_stall_pct = 0;
    bit                      hold_request   = 1'b0;
    int                      quiet_cycles   = 0;
    logic [SITE_FIELD_W-1:0] last_row       = '0;
    logic [SITE_FIELD_W-1:0] last_col       = '0;
    lattice_tracker          tracker;

    always #5 clk = ~clk;

    ising_metropolis_spin_update #(.LATTICE_SIDE(SIDE)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // site_row, site_col, uniform_draw, zero fill
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // flip_accepted, energy_now, magnet_now, energy_sum,
                                // energy_sq_sum, abs_magnet_sum, magnet_sq_sum, zero fill
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // report monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.match_report(m_tdata);
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                for (int k = 0; k < LONG_HOLD; k++)
                begin
                    m_tready <= 1'b0;
                    @(negedge clk);
                end
                hold_request = 1'b0;
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one word; called and returns at a falling edge.
    task automatic send_site(input logic [SITE_FIELD_W-1:0] row,
                             input logic [SITE_FIELD_W-1:0] col,
                             input logic [DRAW_W-1:0] draw);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W - 2 * SITE_FIELD_W - DRAW_W){1'b0}}, draw, col, row};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        tracker.take_site(row, col, draw);
        last_row = row;
        last_col = col;
        @(negedge clk);
    endtask

    // Write both thresholds, then junk to the undecoded indexes.
    task automatic set_thresholds(input logic [DRAW_W-1:0] four,
                                  input logic [DRAW_W-1:0] eight);
        logic [CFG_INDEX_W-1:0] idx [4];
        logic [CFG_DATA_W-1:0]  val [4];
        idx = '{CFG_THRESH_FOUR, CFG_THRESH_EIGHT, CFG_SPARE_LO, CFG_SPARE_HI};
        val = '{four, eight, $urandom, $urandom};
        foreach (idx[k])
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            tracker.write_reg(idx[k], val[k]);
            @(negedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    // Drop valid and wait for every predicted report, then a few quiet cycles.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic random_phase(input int send_pct, input int recv_pct, input bit long_hold);
        logic [SITE_FIELD_W-1:0] row;
        logic [SITE_FIELD_W-1:0] col;
        logic [DRAW_W-1:0]       draw;
        int                      pick;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (long_hold)
            hold_request = 1'b1;
        repeat (PHASE_ITEMS)
        begin
            pick = $urandom_range(99);
            row  = last_row;
            col  = last_col;
            if (pick < 45)
            begin
                // revisit the last site or a neighbor to hit back-to-back hazards
                case ($urandom_range(4))
                    1: row = row + 1'b1;
                    2: row = row - 1'b1;
                    3: col = col + 1'b1;
                    4: col = col - 1'b1;
                    default: ;
                endcase
            end
            else if (pick < 90)
            begin
                row = SITE_FIELD_W'($urandom_range(SIDE - 1));
                col = SITE_FIELD_W'($urandom_range(SIDE - 1));
            end
            else
            begin
                row = $urandom_range(1) ? SITE_FIELD_W'(SIDE - 1) : '0;
                col = $urandom_range(1) ? SITE_FIELD_W'(SIDE - 1) : '0;
            end
            case ($urandom_range(19))
                0: draw = '0;
                1: draw = '1;
                2: draw = tracker.thresh_four;
                3: draw = tracker.thresh_eight - 1'b1;
                default: draw = $urandom;
            endcase
            send_site(row, col, draw);
        end
        settle();
    endtask

    initial
    begin
        tracker = new();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        // hold off until the post-reset lattice sweep opens the input
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        @(negedge clk);

        // thresholds at reset: any energy rise is refused, even with a zero draw
        send_site(5'd0, 5'd0, '0);
        send_site(5'd31, 5'd31, '1);
        send_site(5'd31, 5'd0, '0);
        settle();

        set_thresholds('1, '1);
        send_site(5'd0, 5'd0, '0);              // rise of 8, taken
        send_site(5'd0, 5'd2, 32'h1234_5678);
        send_site(5'd0, 5'd1, '1);              // zero energy change, draw ignored
        send_site(5'd0, 5'd0, '1);              // drop of 4
        send_site(5'd31, 5'd31, '1);            // draw equal to threshold, refused
        send_site(5'd0, 5'd1, '0);
        send_site(5'd31, 5'd31, 32'hFFFF_FFFE); // neighbors wrap onto row 0 and column 0
        send_site(5'd31, 5'd0, '1);
        settle();

        // threshold boundary on both rises, then drops of 4 and 8
        set_thresholds(32'h8000_0000, 32'h8000_0000);
        send_site(5'd16, 5'd16, 32'h7FFF_FFFF);
        send_site(5'd20, 5'd20, 32'h8000_0000);
        send_site(5'd16, 5'd17, 32'h7FFF_FFFF);
        send_site(5'd17, 5'd16, 32'h8000_0000);
        send_site(5'd16, 5'd16, '0);
        send_site(5'd16, 5'd17, '1);
        settle();

        set_thresholds('1, '1);
        random_phase(0, 0, 1'b1);
        set_thresholds(CRIT_FOUR, CRIT_EIGHT);
        random_phase(61, 0, 1'b0);
        set_thresholds($urandom, $urandom);
        random_phase(0, 61, 1'b0);
        set_thresholds('0, '1);
        random_phase(22, 22, 1'b0);
        set_thresholds('1, '0);
        random_phase(22, 22, 1'b0);

        if (tracker.fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
